### hw/rtl/assert_macros.svh
// Assertion macros shared by the boid flock update RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### hw/rtl/bfu_pkg.sv
// Package for the boid flock update block: types and fixed constants.
// Depends on nothing.
`default_nettype none
package bfu_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_LEFT   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RIGHT  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TOP    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_BOTTOM = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RADIUS = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PUSH   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SPEED  = 3'd6;
	localparam logic [31:0] RST_POS_X = 32'd134217728;
	localparam logic [31:0] RST_POS_Y = 32'd134217729;
	localparam logic [31:0] RST_VEL   = 32'd20971520;
	localparam int unsigned COH_SHIFT = 6;
	localparam int unsigned SEP_SHIFT = 4;
	localparam int unsigned ALI_SHIFT = 2;

	typedef struct packed {
		logic [30:0] x_lo;
		logic [30:0] x_hi;
		logic [30:0] y_lo;
		logic [30:0] y_hi;
		logic [30:0] near_radius;
		logic [30:0] wall_kick;
		logic [4:0]  speed_limit_log;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_SELF, ST_SCAN, ST_DRAIN, ST_ACC, ST_ACCW,
		ST_COMB, ST_LIMIT, ST_PUSH, ST_WRITE, ST_OUT
	} state_t;

	// Arithmetic shift right by a 5-bit amount.
	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		asr = 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] mag(input logic [31:0] v);
		mag = v[31] ? (32'd0 - v) : v;
	endfunction
endpackage
`default_nettype wire

### hw/rtl/bfu_front.sv
// Front part: accepts boid indexes from the input stream and queues them.
// Depends on nothing.
`default_nettype none
module bfu_front #(
	parameter int unsigned IdxW = 9,
	parameter int unsigned Depth = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [IdxW-1:0] in_idx,
	output logic                 q_valid,
	input  wire logic            q_ready,
	output logic [IdxW-1:0]      q_idx
);
	localparam int unsigned PW = $clog2(Depth);
	logic [IdxW-1:0] mem_q [Depth];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (PW+1)'(Depth));
	assign q_valid  = (cnt_q != '0);
	assign q_idx    = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_idx;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

### hw/rtl/bfu_back.sv
// Back part: neighbor scan over the boid memories and velocity update.
// Depends on bfu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bfu_back #(
	parameter int unsigned BoidCount = 512,
	parameter int unsigned NeighborCount = 4,
	parameter int unsigned IdxW = 9
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bfu_pkg::cfg_t   cfg,
	input  wire logic            q_valid,
	output logic                 q_ready,
	input  wire logic [IdxW-1:0] q_idx,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [IdxW-1:0]      out_idx,
	output logic [31:0]          out_px,
	output logic [31:0]          out_py,
	output logic [31:0]          out_vx,
	output logic [31:0]          out_vy
);
	localparam int unsigned AW = $clog2(BoidCount);
	localparam int unsigned NW = (NeighborCount > 1) ? $clog2(NeighborCount) : 1;
	localparam int unsigned CW = $clog2(NeighborCount + 1);
	localparam logic [4:0] MS = 5'($clog2(NeighborCount + 1) - 1);

	// Boid memories
	logic [31:0] px_mem [BoidCount];
	logic [31:0] py_mem [BoidCount];
	logic [31:0] vx_mem [BoidCount];
	logic [31:0] vy_mem [BoidCount];

	bfu_pkg::state_t st_q, st_d;
	logic [AW:0] cnt_q;
	logic [AW-1:0] rd_addr;
	logic [31:0] rpx_q, rpy_q, rvx_q, rvy_q;
	logic rd_ok_s1;
	logic [AW-1:0] rd_j_s1;
	logic [IdxW-1:0] idx_q;
	logic oor_q;
	logic [31:0] spx_q, spy_q, svx_q, svy_q;
	logic [AW-1:0] nb_q [NeighborCount];
	logic [31:0] nd_q [NeighborCount];
	logic [CW-1:0] ncnt_q;
	logic [NW:0] k_q;
	logic [31:0] cx_q, cy_q, rx_q, ry_q, ax_q, ay_q, tx_q, ty_q;
	logic [33:0] sp_q;
	logic sp_ld_q;
	logic [5:0] lg_q;
	logic [31:0] opx_q, opy_q, ovx_q, ovy_q;
	logic [IdxW-1:0] oidx_q;
	logic ov_q;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [31:0] wpx, wpy, wvx, wvy;

	// Read address per state
	always_comb begin
		rd_addr = cnt_q[AW-1:0];
		case (st_q)
			bfu_pkg::ST_SELF: rd_addr = AW'(idx_q);
			bfu_pkg::ST_ACC:  rd_addr = nb_q[k_q[NW-1:0]];
			default: rd_addr = cnt_q[AW-1:0];
		endcase
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			px_mem[mem_wa] <= wpx;
			py_mem[mem_wa] <= wpy;
			vx_mem[mem_wa] <= wvx;
			vy_mem[mem_wa] <= wvy;
		end
		rpx_q <= px_mem[rd_addr];
		rpy_q <= py_mem[rd_addr];
		rvx_q <= vx_mem[rd_addr];
		rvy_q <= vy_mem[rd_addr];
	end

	assign mem_we = (st_q == bfu_pkg::ST_CLEAR) || (st_q == bfu_pkg::ST_WRITE);
	always_comb begin
		if (st_q == bfu_pkg::ST_CLEAR) begin
			mem_wa = cnt_q[AW-1:0];
			wpx = bfu_pkg::RST_POS_X + 32'(cnt_q[AW-1:0]);
			wpy = bfu_pkg::RST_POS_Y;
			wvx = bfu_pkg::RST_VEL;
			wvy = bfu_pkg::RST_VEL;
		end else begin
			mem_wa = AW'(idx_q);
			wpx = spx_q + ax_q;
			wpy = spy_q + ay_q;
			wvx = ax_q;
			wvy = ay_q;
		end
	end

	// Distance of the boid read last cycle
	logic [31:0] dcur;
	logic [NW:0] ins_p;
	assign dcur = bfu_pkg::mag(spx_q - rpx_q) + bfu_pkg::mag(spy_q - rpy_q);
	always_comb begin
		ins_p = (NW+1)'(ncnt_q);
		for (int k = NeighborCount - 1; k >= 0; k--) begin
			if (CW'(k) < ncnt_q && $signed(dcur) < $signed(nd_q[k])) ins_p = (NW+1)'(k);
		end
	end

	// Neighbor accumulation: one neighbor per ST_ACC/ST_ACCW pair (read then add)
	logic acc_en;
	logic [NW:0] acc_k;
	assign acc_k = k_q - 1'b1;
	assign acc_en = (st_q == bfu_pkg::ST_ACCW) && ((NW+1)'(ncnt_q) > acc_k);

	// Separation test for the neighbor being added
	logic sep_hit;
	assign sep_hit = $signed(nd_q[acc_k[NW-1:0]]) < $signed({1'b0, cfg.near_radius});

	// Speed log shift amount, saturated at 31
	logic [5:0] lg_shift;
	logic [4:0] sh_amt;
	assign lg_shift = lg_q - {1'b0, cfg.speed_limit_log};
	assign sh_amt = (lg_shift > 6'd31) ? 5'd31 : lg_shift[4:0];

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			bfu_pkg::ST_CLEAR: if (cnt_q == (AW+1)'(BoidCount - 1)) st_d = bfu_pkg::ST_IDLE;
			bfu_pkg::ST_IDLE: if (q_valid && !ov_q) st_d = bfu_pkg::ST_SELF;
			bfu_pkg::ST_SELF: st_d = oor_q ? bfu_pkg::ST_OUT : bfu_pkg::ST_SCAN;
			bfu_pkg::ST_SCAN: if (cnt_q == (AW+1)'(BoidCount)) st_d = bfu_pkg::ST_DRAIN;
			bfu_pkg::ST_DRAIN: st_d = bfu_pkg::ST_ACC;
			bfu_pkg::ST_ACC: st_d = bfu_pkg::ST_ACCW;
			bfu_pkg::ST_ACCW: st_d = ((NW+1)'(ncnt_q) > k_q) ? bfu_pkg::ST_ACC
				: bfu_pkg::ST_COMB;
			bfu_pkg::ST_COMB: st_d = bfu_pkg::ST_LIMIT;
			bfu_pkg::ST_LIMIT: if (sp_ld_q && sp_q <= 34'd1) st_d = bfu_pkg::ST_PUSH;
			bfu_pkg::ST_PUSH: st_d = bfu_pkg::ST_WRITE;
			bfu_pkg::ST_WRITE: st_d = bfu_pkg::ST_OUT;
			bfu_pkg::ST_OUT: st_d = bfu_pkg::ST_IDLE;
			default: st_d = bfu_pkg::ST_IDLE;
		endcase
	end
	assign q_ready = (st_q == bfu_pkg::ST_IDLE) && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= bfu_pkg::ST_CLEAR;
		else st_q <= st_d;
	end

	// Control counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_ok_s1 <= 1'b0;
			ncnt_q <= '0;
			k_q <= '0;
			ov_q <= 1'b0;
		end else begin
			rd_ok_s1 <= (st_q == bfu_pkg::ST_SCAN) && (cnt_q != (AW+1)'(BoidCount));
			case (st_q)
				bfu_pkg::ST_CLEAR: cnt_q <= cnt_q + 1'b1;
				bfu_pkg::ST_IDLE: begin
					cnt_q <= '0;
					ncnt_q <= '0;
				end
				bfu_pkg::ST_SCAN: if (cnt_q != (AW+1)'(BoidCount)) cnt_q <= cnt_q + 1'b1;
				bfu_pkg::ST_DRAIN: k_q <= '0;
				bfu_pkg::ST_ACC: k_q <= k_q + 1'b1;
				default: ;
			endcase
			if ((st_q == bfu_pkg::ST_SCAN || st_q == bfu_pkg::ST_DRAIN) && rd_ok_s1 &&
				ins_p < (NW+1)'(NeighborCount) && ncnt_q < CW'(NeighborCount))
				ncnt_q <= ncnt_q + 1'b1;
			if (st_q == bfu_pkg::ST_OUT) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		rd_j_s1 <= cnt_q[AW-1:0];
		case (st_q)
			bfu_pkg::ST_IDLE: begin
				idx_q <= q_idx;
				oor_q <= (32'(q_idx) >= 32'(BoidCount));
			end
			bfu_pkg::ST_SELF: ;
			bfu_pkg::ST_SCAN, bfu_pkg::ST_DRAIN: begin
				if (st_q == bfu_pkg::ST_SCAN && cnt_q == '0) begin
					spx_q <= rpx_q; spy_q <= rpy_q; svx_q <= rvx_q; svy_q <= rvy_q;
				end
				if (rd_ok_s1 && ins_p < (NW+1)'(NeighborCount)) begin
					for (int k = NeighborCount - 1; k > 0; k--) begin
						if ((NW+1)'(k) > ins_p) begin
							nb_q[k] <= nb_q[k-1];
							nd_q[k] <= nd_q[k-1];
						end
					end
					nb_q[ins_p[NW-1:0]] <= rd_j_s1;
					nd_q[ins_p[NW-1:0]] <= dcur;
				end
			end
			default: ;
		endcase
	end

	// Clear the sums, add one neighbor per read, combine, limit and push
	always_ff @(posedge clk) begin
		if (st_q == bfu_pkg::ST_IDLE) begin
			cx_q <= '0; cy_q <= '0; rx_q <= '0; ry_q <= '0; tx_q <= '0; ty_q <= '0;
		end else if (acc_en) begin
			cx_q <= cx_q + bfu_pkg::asr(rpx_q, MS);
			cy_q <= cy_q + bfu_pkg::asr(rpy_q, MS);
			tx_q <= tx_q + bfu_pkg::asr(rvx_q, MS);
			ty_q <= ty_q + bfu_pkg::asr(rvy_q, MS);
			if (sep_hit) begin
				rx_q <= rx_q + (spx_q - rpx_q);
				ry_q <= ry_q + (spy_q - rpy_q);
			end
		end
		case (st_q)
			bfu_pkg::ST_COMB: begin
				ax_q <= svx_q + bfu_pkg::asr(cx_q - spx_q, 5'(bfu_pkg::COH_SHIFT))
					+ bfu_pkg::asr(rx_q, 5'(bfu_pkg::SEP_SHIFT))
					+ bfu_pkg::asr(tx_q, 5'(bfu_pkg::ALI_SHIFT));
				ay_q <= svy_q + bfu_pkg::asr(cy_q - spy_q, 5'(bfu_pkg::COH_SHIFT))
					+ bfu_pkg::asr(ry_q, 5'(bfu_pkg::SEP_SHIFT))
					+ bfu_pkg::asr(ty_q, 5'(bfu_pkg::ALI_SHIFT));
				lg_q <= '0;
			end
			bfu_pkg::ST_LIMIT: begin
				if (sp_ld_q && sp_q > 34'd1) lg_q <= lg_q + 1'b1;
				else if (sp_ld_q && lg_q > {1'b0, cfg.speed_limit_log}) begin
					ax_q <= bfu_pkg::asr(ax_q, sh_amt);
					ay_q <= bfu_pkg::asr(ay_q, sh_amt);
				end
			end
			bfu_pkg::ST_PUSH: begin
				if ($signed(spx_q) < $signed({1'b0, cfg.x_lo}))
					ax_q <= ax_q + {1'b0, cfg.wall_kick};
				else if ($signed(spx_q) > $signed({1'b0, cfg.x_hi}))
					ax_q <= ax_q - {1'b0, cfg.wall_kick};
				if ($signed(spy_q) < $signed({1'b0, cfg.y_lo}))
					ay_q <= ay_q + {1'b0, cfg.wall_kick};
				else if ($signed(spy_q) > $signed({1'b0, cfg.y_hi}))
					ay_q <= ay_q - {1'b0, cfg.wall_kick};
			end
			default: ;
		endcase
	end

	// Speed magnitude: load once, then halve once per limit cycle to find log2
	always_ff @(posedge clk) begin
		if (st_q == bfu_pkg::ST_COMB) sp_ld_q <= 1'b0;
		else if (st_q == bfu_pkg::ST_LIMIT && !sp_ld_q) begin
			sp_q <= 34'(bfu_pkg::mag(ax_q)) + 34'(bfu_pkg::mag(ay_q));
			sp_ld_q <= 1'b1;
		end else if (st_q == bfu_pkg::ST_LIMIT) sp_q <= sp_q >> 1;
	end

	// Output register
	always_ff @(posedge clk) begin
		if (st_q == bfu_pkg::ST_OUT) begin
			oidx_q <= idx_q;
			opx_q <= oor_q ? '0 : spx_q + ax_q;
			opy_q <= oor_q ? '0 : spy_q + ay_q;
			ovx_q <= oor_q ? '0 : ax_q;
			ovy_q <= oor_q ? '0 : ay_q;
		end
	end
	assign out_valid = ov_q;
	assign out_idx = oidx_q;
	assign out_px = opx_q;
	assign out_py = opy_q;
	assign out_vx = ovx_q;
	assign out_vy = ovy_q;

	`ASSERT_IMPL(a_no_take_busy, clk, arst_n, q_ready, st_q == bfu_pkg::ST_IDLE, "take while busy")
	`ASSERT_IMPL(a_ncnt_max, clk, arst_n, 1'b1, ncnt_q <= CW'(NeighborCount), "neighbor overflow")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, ov_q && !out_ready, ov_q, "result dropped")
endmodule
`default_nettype wire

### hw/rtl/boid_flock_update.sv
// Boid flock update: top level with configuration registers.
// Depends on bfu_pkg, bfu_front and bfu_back.
//
// Usage: s_axis carries a boid index (tdata[8:0]); m_axis returns one result
// per index with the updated position and velocity. cfg_valid/cfg_ready write
// register cfg_index with cfg_data; write only while no index is in flight.
// The time from the index transfer to the result is set by the neighbor
// scan, which reads one boid per cycle from the state memories, by the
// summing of the terms with a read and an add per neighbor, and by the
// bit-serial log2 of the speed. An index at or above BOID_COUNT returns
// zero fields and changes nothing.
// Throughput: one index at a time; the next starts once the result is taken.
// After reset a clearing pass writes the reset state of every boid, one
// boid per cycle, during which the back end takes no index from the queue.
// A stalled receiver holds the result in the output register and the back
// end waits; two further indexes wait in the input queue, then
// s_axis_tready drops.
`default_nettype none
module boid_flock_update #(
	parameter int unsigned BOID_COUNT = 512,
	parameter int unsigned NEIGHBOR_COUNT = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [15:0]  s_axis_tdata,  // [8:0] index of the boid to update
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [8:0] updated_index, [40:9] new_pos_x, [72:41] new_pos_y,
	// [104:73] new_vel_x, [136:105] new_vel_y
	output logic [143:0]      m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	bfu_pkg::cfg_t cfg_q;
	logic q_valid, q_ready;
	logic [8:0] q_idx, o_idx;
	logic [31:0] opx, opy, ovx, ovy;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_lo <= 31'd134217728;
			cfg_q.x_hi <= 31'd939524096;
			cfg_q.y_lo <= 31'd134217728;
			cfg_q.y_hi <= 31'd939524096;
			cfg_q.near_radius <= 31'd20971520;
			cfg_q.wall_kick <= 31'd2097152;
			cfg_q.speed_limit_log <= 5'd23;
		end else if (cfg_valid) begin
			case (cfg_index)
				bfu_pkg::REG_LEFT:   cfg_q.x_lo <= cfg_data[30:0];
				bfu_pkg::REG_RIGHT:  cfg_q.x_hi <= cfg_data[30:0];
				bfu_pkg::REG_TOP:    cfg_q.y_lo <= cfg_data[30:0];
				bfu_pkg::REG_BOTTOM: cfg_q.y_hi <= cfg_data[30:0];
				bfu_pkg::REG_RADIUS: cfg_q.near_radius <= cfg_data[30:0];
				bfu_pkg::REG_PUSH:   cfg_q.wall_kick <= cfg_data[30:0];
				bfu_pkg::REG_SPEED:  cfg_q.speed_limit_log <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	bfu_front #(.IdxW(9), .Depth(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_idx(s_axis_tdata[8:0]),
		.q_valid(q_valid), .q_ready(q_ready), .q_idx(q_idx)
	);

	bfu_back #(.BoidCount(BOID_COUNT), .NeighborCount(NEIGHBOR_COUNT), .IdxW(9)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_idx(q_idx),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_idx(o_idx),
		.out_px(opx), .out_py(opy), .out_vx(ovx), .out_vy(ovy)
	);

	assign m_axis_tdata = {7'd0, ovy, ovx, opy, opx, o_idx};
endmodule
`default_nettype wire

### tb/bfu_checker.sv
// Checker for the boid flock update block: watches the index, result and register write channels.
// Keeps its own boid state, predicts every result and compares it field by field. Depends on bfu_pkg.
`timescale 1ns / 100ps
module bfu_checker #(
	parameter int unsigned BOIDS = 512,
	parameter int unsigned NEAR = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [15:0]  s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [143:0] m_axis_tdata,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output int                errors,
	output int                pending
);
	// Fields from the lowest bit up: index, pos x, pos y, vel x, vel y
	typedef struct packed {
		logic [31:0] vy;
		logic [31:0] vx;
		logic [31:0] py;
		logic [31:0] px;
		logic [8:0]  idx;
	} boid_out_t;

	logic [31:0] pos_x [BOIDS];
	logic [31:0] pos_y [BOIDS];
	logic [31:0] vel_x [BOIDS];
	logic [31:0] vel_y [BOIDS];
	bfu_pkg::cfg_t regs;
	boid_out_t updates_due[$];

	function automatic logic [31:0] sra(input logic [31:0] v, input int s);
		return 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] absval(input logic [31:0] v);
		return v[31] ? -v : v;
	endfunction

	// Compute one boid update and commit it to the local state.
	function automatic boid_out_t update_boid(input logic [8:0] who);
		boid_out_t r;
		int nb [NEAR];
		logic [31:0] nd [NEAR];
		int cnt, p, ms, lg, sh;
		logic [31:0] d, cx, cy, rx, ry, ax, ay, sx, sy;
		logic [32:0] speed;
		cnt = 0;
		ms = $clog2(NEAR + 1) - 1;
		cx = 0; cy = 0; rx = 0; ry = 0; sx = 0; sy = 0;
		r = '0;
		r.idx = who;
		if (who >= BOIDS) return r;
		// sorted insert of the nearest boids; ties keep the earlier one
		for (int j = 0; j < BOIDS; j++) begin
			d = absval(pos_x[who] - pos_x[j]) + absval(pos_y[who] - pos_y[j]);
			p = cnt;
			for (int k = 0; k < cnt; k++)
				if ($signed(d) < $signed(nd[k])) begin
					p = k;
					break;
				end
			if (p >= NEAR) continue;
			if (cnt < NEAR) cnt++;
			for (int k = cnt - 1; k > p; k--) begin
				nb[k] = nb[k-1];
				nd[k] = nd[k-1];
			end
			nb[p] = j;
			nd[p] = d;
		end
		for (int k = 0; k < cnt; k++) begin
			cx += sra(pos_x[nb[k]], ms);
			cy += sra(pos_y[nb[k]], ms);
			if ($signed(nd[k]) < $signed({1'b0, regs.near_radius})) begin
				rx += pos_x[who] - pos_x[nb[k]];
				ry += pos_y[who] - pos_y[nb[k]];
			end
			sx += sra(vel_x[nb[k]], ms);
			sy += sra(vel_y[nb[k]], ms);
		end
		ax = vel_x[who] + sra(cx - pos_x[who], bfu_pkg::COH_SHIFT)
			+ sra(rx, bfu_pkg::SEP_SHIFT) + sra(sx, bfu_pkg::ALI_SHIFT);
		ay = vel_y[who] + sra(cy - pos_y[who], bfu_pkg::COH_SHIFT)
			+ sra(ry, bfu_pkg::SEP_SHIFT) + sra(sy, bfu_pkg::ALI_SHIFT);
		// limit the speed
		speed = {1'b0, absval(ax)} + {1'b0, absval(ay)};
		lg = 0;
		for (int b = 0; b < 33; b++)
			if (speed[b]) lg = b;
		if (lg > regs.speed_limit_log) begin
			sh = lg - regs.speed_limit_log;
			ax = sra(ax, sh);
			ay = sra(ay, sh);
		end
		// push back from the edges
		if ($signed(pos_x[who]) < $signed({1'b0, regs.x_lo}))
			ax += {1'b0, regs.wall_kick};
		else if ($signed(pos_x[who]) > $signed({1'b0, regs.x_hi}))
			ax -= {1'b0, regs.wall_kick};
		if ($signed(pos_y[who]) < $signed({1'b0, regs.y_lo}))
			ay += {1'b0, regs.wall_kick};
		else if ($signed(pos_y[who]) > $signed({1'b0, regs.y_hi}))
			ay -= {1'b0, regs.wall_kick};
		vel_x[who] = ax;
		vel_y[who] = ay;
		pos_x[who] += ax;
		pos_y[who] += ay;
		r.px = pos_x[who];
		r.py = pos_y[who];
		r.vx = ax;
		r.vy = ay;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		for (int i = 0; i < BOIDS; i++) begin
			pos_x[i] = bfu_pkg::RST_POS_X + 32'(i);
			pos_y[i] = bfu_pkg::RST_POS_Y;
			vel_x[i] = bfu_pkg::RST_VEL;
			vel_y[i] = bfu_pkg::RST_VEL;
		end
		regs = '{31'd134217728, 31'd939524096, 31'd134217728, 31'd939524096,
			31'd20971520, 31'd2097152, 5'd23};
	end

	assign pending = updates_due.size();

	// Predict on each index transfer, apply register writes, check each result transfer.
	always @(posedge clk) begin
		boid_out_t want;
		boid_out_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bfu_pkg::REG_LEFT:   regs.x_lo = cfg_data[30:0];
					bfu_pkg::REG_RIGHT:  regs.x_hi = cfg_data[30:0];
					bfu_pkg::REG_TOP:    regs.y_lo = cfg_data[30:0];
					bfu_pkg::REG_BOTTOM: regs.y_hi = cfg_data[30:0];
					bfu_pkg::REG_RADIUS: regs.near_radius = cfg_data[30:0];
					bfu_pkg::REG_PUSH:   regs.wall_kick = cfg_data[30:0];
					bfu_pkg::REG_SPEED:  regs.speed_limit_log = cfg_data[4:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				updates_due.push_back(update_boid(s_axis_tdata[8:0]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[136:0];
				if (updates_due.size() == 0) begin
					report("unexpected result index", 32'(got.idx), 32'd0);
				end else begin
					want = updates_due.pop_front();
					if (got.idx !== want.idx) report("updated_index", 32'(got.idx), 32'(want.idx));
					if (got.px !== want.px) report("new_pos_x", got.px, want.px);
					if (got.py !== want.py) report("new_pos_y", got.py, want.py);
					if (got.vx !== want.vx) report("new_vel_x", got.vx, want.vx);
					if (got.vy !== want.vy) report("new_vel_y", got.vy, want.vy);
				end
			end
		end
	end
endmodule

### tb/tb.sv
// Testbench top for the boid flock update block: clock, reset, index stimulus and register writes.
// Depends on bfu_pkg, boid_flock_update and bfu_checker.
`timescale 1ns / 100ps
module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int errors, pending;
	bit indexes_done = 1'b0;

	boid_flock_update uut (.*);
	bfu_checker chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Write one register, then idle the channel for a cycle.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Send one index after a random gap; valid stays high when the gap is zero.
	task automatic send_index(input logic [15:0] idx);
		int w;
		w = $urandom_range(0, 3);
		if (w != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= idx;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop valid, wait for all results, then let the block settle before a register write.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	// Pick an index: mostly a small cluster so neighbors interact, sometimes out of range.
	function automatic logic [15:0] pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 16'($urandom_range(512, 65535));
		if (r < 60) return 16'($urandom_range(0, 15));
		return 16'($urandom_range(0, 511));
	endfunction

	// Receiver waits a random gap before taking each result.
	always begin : rx_side
		int w;
		w = $urandom_range(0, 3);
		if (w != 0) begin
			m_axis_tready <= 1'b0;
			repeat (w) @(posedge clk);
		end
		m_axis_tready <= 1'b1;
		do @(posedge clk); while (!m_axis_tvalid);
	end

	initial begin
		logic [15:0] edge_idx [8];
		edge_idx = '{16'd0, 16'd511, 16'd1, 16'd256, 16'd512, 16'hFFFF, 16'hAAAA, 16'h5555};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extreme indexes on reset settings
		foreach (edge_idx[i]) send_index(edge_idx[i]);
		for (int i = 0; i < 8; i++) send_index(16'(i));
		drain();
		// extreme settings: bounds, radius and speed limit at their ends, a large push
		write_reg(bfu_pkg::REG_LEFT, 32'hFFFF_FFFF);
		write_reg(bfu_pkg::REG_RIGHT, 32'd0);
		write_reg(bfu_pkg::REG_TOP, 32'h7FFF_FFFF);
		write_reg(bfu_pkg::REG_BOTTOM, 32'd0);
		write_reg(bfu_pkg::REG_RADIUS, 32'h7FFF_FFFF);
		write_reg(bfu_pkg::REG_PUSH, 32'h4000_0000);
		write_reg(bfu_pkg::REG_SPEED, 32'd0);
		for (int i = 0; i < 6; i++) send_index(16'(i));
		drain();
		write_reg(bfu_pkg::REG_SPEED, 32'hFFFF_FFFF);
		write_reg(bfu_pkg::REG_PUSH, 32'd0);
		write_reg(bfu_pkg::REG_RADIUS, 32'd0);
		for (int i = 0; i < 4; i++) send_index(16'(i * 3));
		drain();
		// random phases with random settings
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 7; r++)
				write_reg(3'(r), $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 1 << 30));
			write_reg(bfu_pkg::REG_SPEED, $urandom_range(10, 31));
			for (int n = 0; n < 115; n++) send_index(pick_index());
			drain();
		end
		// restore reset-like settings for the last stretch
		write_reg(bfu_pkg::REG_LEFT, 32'd134217728);
		write_reg(bfu_pkg::REG_RIGHT, 32'd939524096);
		write_reg(bfu_pkg::REG_TOP, 32'd134217728);
		write_reg(bfu_pkg::REG_BOTTOM, 32'd939524096);
		write_reg(bfu_pkg::REG_RADIUS, 32'd20971520);
		write_reg(bfu_pkg::REG_PUSH, 32'd2097152);
		write_reg(bfu_pkg::REG_SPEED, 32'd23);
		for (int n = 0; n < 10; n++) send_index(pick_index());
		s_axis_tvalid <= 1'b0;
		indexes_done = 1'b1;
	end

	initial begin
		wait (indexes_done);
		while (pending != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		if (errors == 0)
			$display("boid_flock_update: match");
		else
			$display("boid_flock_update: mismatch");
		$finish;
	end

	initial begin
		#80ms;
		$display("boid_flock_update: mismatch");
		$finish;
	end
endmodule
